// ----- rtl/core/dvd_cta_pkg.sv -----
// Shared types, constants and decode helpers for the DVD cell time accumulator.
// No dependencies; used by every module of the block.
package dvd_cta_pkg;

    localparam int TOTAL_W = 37;
    localparam int DUR_W   = 29;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_STILL = 2'd1;
    localparam logic [1:0] ERR_TIME  = 2'd2;
    localparam logic [1:0] ERR_ZERO  = 2'd3;

    localparam logic [1:0] RATE_25 = 2'd1;
    localparam logic [1:0] RATE_30 = 2'd3;

    // Classified cell, as handed from front to back
    typedef struct packed {
        logic             title_start;
        logic             program_first;
        logic             last_cell;
        logic             skip;
        logic             still_err;
        logic             time_err;
        logic [DUR_W-1:0] dur;
    } t_cell;

    function automatic logic bcd_ok(input logic [7:0] b);
        return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
    endfunction

    function automatic logic [6:0] bcd_val(input logic [7:0] b);
        return 7'(b[7:4]) * 7'd10 + 7'(b[3:0]);
    endfunction

    // frames * 1000 / 30, truncated, for frames below 30
    function automatic logic [9:0] frame_ms_30(input logic [5:0] f);
        logic [9:0] v;
        case (f)
            6'd0:  v = 10'd0;
            6'd1:  v = 10'd33;
            6'd2:  v = 10'd66;
            6'd3:  v = 10'd100;
            6'd4:  v = 10'd133;
            6'd5:  v = 10'd166;
            6'd6:  v = 10'd200;
            6'd7:  v = 10'd233;
            6'd8:  v = 10'd266;
            6'd9:  v = 10'd300;
            6'd10: v = 10'd333;
            6'd11: v = 10'd366;
            6'd12: v = 10'd400;
            6'd13: v = 10'd433;
            6'd14: v = 10'd466;
            6'd15: v = 10'd500;
            6'd16: v = 10'd533;
            6'd17: v = 10'd566;
            6'd18: v = 10'd600;
            6'd19: v = 10'd633;
            6'd20: v = 10'd666;
            6'd21: v = 10'd700;
            6'd22: v = 10'd733;
            6'd23: v = 10'd766;
            6'd24: v = 10'd800;
            6'd25: v = 10'd833;
            6'd26: v = 10'd866;
            6'd27: v = 10'd900;
            6'd28: v = 10'd933;
            6'd29: v = 10'd966;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/dvd_cta_front.sv -----
// Front end: checks and decodes one cell entry into a classified record.
// Depends on dvd_cta_pkg.
module dvd_cta_front (
    input  logic                  i_title_start,
    input  logic                  i_program_first,
    input  logic                  i_last_cell,
    input  logic [1:0]            i_angle_mode,
    input  logic [7:0]            i_still_byte,
    input  logic [7:0]            i_hours_bcd,
    input  logic [7:0]            i_minutes_bcd,
    input  logic [7:0]            i_seconds_bcd,
    input  logic [7:0]            i_frame_byte,
    output dvd_cta_pkg::t_cell    o_cell
);

    logic [1:0]  rate;
    logic [5:0]  frames;
    logic [6:0]  hh, mm, ss;
    logic        digits_ok;
    logic        frames_ok;
    logic [9:0]  frame_ms;
    logic [dvd_cta_pkg::DUR_W-1:0] dur;

    always_comb begin
        rate   = i_frame_byte[7:6];
        frames = 6'(i_frame_byte[5:4]) * 6'd10 + 6'(i_frame_byte[3:0]);
        hh     = dvd_cta_pkg::bcd_val(i_hours_bcd);
        mm     = dvd_cta_pkg::bcd_val(i_minutes_bcd);
        ss     = dvd_cta_pkg::bcd_val(i_seconds_bcd);

        digits_ok = dvd_cta_pkg::bcd_ok(i_hours_bcd) && dvd_cta_pkg::bcd_ok(i_minutes_bcd)
                 && dvd_cta_pkg::bcd_ok(i_seconds_bcd) && (mm < 7'd60) && (ss < 7'd60);

        case (rate)
            dvd_cta_pkg::RATE_25: begin
                frames_ok = frames < 6'd25;
                frame_ms  = 10'(frames) * 10'd40;
            end
            dvd_cta_pkg::RATE_30: begin
                frames_ok = frames < 6'd30;
                frame_ms  = dvd_cta_pkg::frame_ms_30(frames);
            end
            default: begin
                frames_ok = frames == 6'd0;
                frame_ms  = 10'd0;
            end
        endcase

        dur = dvd_cta_pkg::DUR_W'(hh) * 29'd3600000
            + dvd_cta_pkg::DUR_W'(mm) * 29'd60000
            + dvd_cta_pkg::DUR_W'(ss) * 29'd1000
            + dvd_cta_pkg::DUR_W'(frame_ms);

        o_cell.title_start   = i_title_start;
        o_cell.program_first = i_program_first;
        o_cell.last_cell     = i_last_cell;
        o_cell.skip          = i_angle_mode[1];
        o_cell.still_err     = i_still_byte != 8'd0;
        o_cell.time_err      = !(digits_ok && frames_ok);
        o_cell.dur           = dur;
    end

endmodule

// ----- rtl/core/dvd_cta_queue.sv -----
// Short FIFO of classified cells between front and back.
// Depends on dvd_cta_pkg.
module dvd_cta_queue #(
    parameter int DEPTH = dvd_cta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  dvd_cta_pkg::t_cell i_wr_data,
    output logic               o_full,
    input  logic               i_rd_en,
    output dvd_cta_pkg::t_cell o_rd_data,
    output logic               o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dvd_cta_pkg::t_cell r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               wr_go, rd_go;

    always_comb begin
        wr_go    = i_wr_en && !o_full;
        rd_go    = i_rd_en && !o_empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_go && !rd_go) begin
            n_count = r_count + 1'b1;
        end else if (rd_go && !wr_go) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_full    = r_count == CNT_W'(DEPTH);
    assign o_empty   = r_count == '0;

endmodule

// ----- rtl/core/dvd_cta_back.sv -----
// Back end: applies classified cells to the running total and sticky error,
// and holds the result in the output register. Depends on dvd_cta_pkg.
module dvd_cta_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dvd_cta_pkg::t_cell                i_cell,
    input  logic                              i_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dvd_cta_pkg::TOTAL_W-1:0]   o_cell_start_ms,
    output logic [dvd_cta_pkg::DUR_W-1:0]     o_cell_duration_ms,
    output logic                              o_included,
    output logic                              o_program_start,
    output logic [dvd_cta_pkg::TOTAL_W-1:0]   o_total_ms,
    output logic [1:0]                        o_error_code
);

    logic [dvd_cta_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [1:0]                      r_err,   n_err;
    logic                            r_valid;
    logic [dvd_cta_pkg::TOTAL_W-1:0] r_start, r_out_total;
    logic [dvd_cta_pkg::DUR_W-1:0]   r_dur;
    logic                            r_inc, r_prog;
    logic [1:0]                      r_out_err;

    logic [dvd_cta_pkg::TOTAL_W-1:0] base_total;
    logic [1:0]                      base_err;
    logic [dvd_cta_pkg::TOTAL_W:0]   sum;
    logic [dvd_cta_pkg::DUR_W-1:0]   n_dur;
    logic                            n_inc;

    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_comb begin
        base_total = i_cell.title_start ? '0 : r_total;
        base_err   = i_cell.title_start ? dvd_cta_pkg::ERR_NONE : r_err;
        sum        = {1'b0, base_total} + (dvd_cta_pkg::TOTAL_W + 1)'(i_cell.dur);
        n_total    = base_total;
        n_err      = base_err;
        n_dur      = '0;
        n_inc      = 1'b0;
        if (base_err == dvd_cta_pkg::ERR_NONE && !i_cell.skip) begin
            if (i_cell.still_err) begin
                n_err = dvd_cta_pkg::ERR_STILL;
            end else if (i_cell.time_err) begin
                n_err = dvd_cta_pkg::ERR_TIME;
            end else begin
                n_dur   = i_cell.dur;
                n_inc   = 1'b1;
                n_total = sum[dvd_cta_pkg::TOTAL_W] ? dvd_cta_pkg::TOTAL_MAX
                                                    : sum[dvd_cta_pkg::TOTAL_W-1:0];
            end
        end
        if (n_err == dvd_cta_pkg::ERR_NONE && i_cell.last_cell && n_total == '0) begin
            n_err = dvd_cta_pkg::ERR_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_err   <= dvd_cta_pkg::ERR_NONE;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_total <= n_total;
                r_err   <= n_err;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the result register on every pop; hold otherwise
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_start     <= base_total;
            r_dur       <= n_dur;
            r_inc       <= n_inc;
            r_prog      <= i_cell.program_first;
            r_out_total <= n_total;
            r_out_err   <= n_err;
        end
    end

    assign o_valid            = r_valid;
    assign o_cell_start_ms    = r_start;
    assign o_cell_duration_ms = r_dur;
    assign o_included         = r_inc;
    assign o_program_start    = r_prog;
    assign o_total_ms         = r_out_total;
    assign o_error_code       = r_out_err;

endmodule

// ----- rtl/core/dvd_cell_time_accumulator.sv -----
// Top level of the DVD cell time accumulator: front decoder, queue, back end.
// Depends on dvd_cta_pkg, dvd_cta_front, dvd_cta_queue, dvd_cta_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  cell in | input     | i_valid / o_ready  | title/program/last flags, mode, times
//  result  | output    | o_valid / i_ready  | start, duration, flags, total, error
//
// One cell per cycle sustained while i_ready is high; a cell is written to the
// queue, then popped into the back end's output register that holds its result.
// Synchronous active-low reset clears the total, the sticky error and the queue.
// While the result side stalls, the queue takes up to QUEUE_DEPTH cells before
// o_ready drops.
module dvd_cell_time_accumulator #(
    parameter int QUEUE_DEPTH = dvd_cta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_title_start,
    input  logic                              i_program_first,
    input  logic                              i_last_cell,
    input  logic [1:0]                        i_angle_mode,
    input  logic [7:0]                        i_still_byte,
    input  logic [7:0]                        i_hours_bcd,
    input  logic [7:0]                        i_minutes_bcd,
    input  logic [7:0]                        i_seconds_bcd,
    input  logic [7:0]                        i_frame_byte,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dvd_cta_pkg::TOTAL_W-1:0]   o_cell_start_ms,
    output logic [dvd_cta_pkg::DUR_W-1:0]     o_cell_duration_ms,
    output logic                              o_included,
    output logic                              o_program_start,
    output logic [dvd_cta_pkg::TOTAL_W-1:0]   o_total_ms,
    output logic [1:0]                        o_error_code
);

    dvd_cta_pkg::t_cell front_cell;
    dvd_cta_pkg::t_cell queue_cell;
    logic               queue_full;
    logic               queue_empty;
    logic               back_pop;

    dvd_cta_front u_front (
        .i_title_start   (i_title_start),
        .i_program_first (i_program_first),
        .i_last_cell     (i_last_cell),
        .i_angle_mode    (i_angle_mode),
        .i_still_byte    (i_still_byte),
        .i_hours_bcd     (i_hours_bcd),
        .i_minutes_bcd   (i_minutes_bcd),
        .i_seconds_bcd   (i_seconds_bcd),
        .i_frame_byte    (i_frame_byte),
        .o_cell          (front_cell)
    );

    dvd_cta_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_valid),
        .i_wr_data (front_cell),
        .o_full    (queue_full),
        .i_rd_en   (back_pop),
        .o_rd_data (queue_cell),
        .o_empty   (queue_empty)
    );

    dvd_cta_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cell             (queue_cell),
        .i_empty            (queue_empty),
        .o_pop              (back_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_cell_start_ms    (o_cell_start_ms),
        .o_cell_duration_ms (o_cell_duration_ms),
        .o_included         (o_included),
        .o_program_start    (o_program_start),
        .o_total_ms         (o_total_ms),
        .o_error_code       (o_error_code)
    );

    assign o_ready = !queue_full;

endmodule
